/* src/gha_pkg.sv */
// Shared request codes, status codes, state encoding and control bundle for the handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

   // Request codes carried on the request channel.
   typedef enum logic [2:0] {
      REQ_CREATE  = 3'd0,
      REQ_RESERVE = 3'd1,
      REQ_COMMIT  = 3'd2,
      REQ_DESTROY = 3'd3,
      REQ_QUERY   = 3'd4
   } req_code_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_DONE        = 2'd0,
      STATUS_STALE       = 2'd1,
      STATUS_WRONG_STATE = 2'd2,
      STATUS_NO_FREE     = 2'd3
   } status_type;

   // Sequencer states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Actions chosen by the decision logic for one request.
   typedef struct packed {
      logic       slot_we;
      logic       push;
      logic       pop;
      logic       hw_inc;
      logic       live_inc;
      logic       live_dec;
      status_type status;
      logic       is_live;
   } ctrl_type;

endpackage

/* src/generational_handle_allocator_unit.sv */
// Top level of the generational handle allocator: sequencer, counters, memories and result register.
//
//   Channel   Direction   Beat contents
//   req_      in          req_type, req_handle_slot, req_handle_gen
//   rsp_      out         rsp_out_slot, rsp_out_gen, rsp_status, rsp_is_live, rsp_live_total
//
// Each request runs in two steps: the synchronous reads of the slot memory and the
// free stack, then the decision and write-back. One request is in flight at a time.
// Reset clears the counters, so no clearing pass is needed; slots at or above the
// high-water mark read as all zero regardless of memory contents.
// A stalled result holds the write-back step; a new request is accepted while a
// finished result still waits in the output register.
`timescale 1ns / 1ps

module generational_handle_allocator_unit #(
   parameter int SLOTS    = 1024,
   parameter int GEN_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_type,
   input  logic [$clog2(SLOTS)-1:0]      req_handle_slot,
   input  logic [GEN_BITS-1:0]           req_handle_gen,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [$clog2(SLOTS)-1:0]      rsp_out_slot,
   output logic [GEN_BITS-1:0]           rsp_out_gen,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_is_live,
   output logic [$clog2(SLOTS+1)-1:0]    rsp_live_total
);

   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int CNT_BITS   = $clog2(SLOTS + 1);
   localparam int ENTRY_BITS = GEN_BITS + 2;
   localparam int STACK_BITS = SLOT_BITS + GEN_BITS;

   gha_pkg::state_type state_ff, state_in;
   logic [2:0]              req_type_ff;
   logic [SLOT_BITS-1:0]    req_slot_ff;
   logic [GEN_BITS-1:0]     req_gen_ff;
   logic [CNT_BITS-1:0]     free_depth_ff, free_depth_in;
   logic [CNT_BITS-1:0]     high_water_ff, high_water_in;
   logic [CNT_BITS-1:0]     live_count_ff, live_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0]    rsp_slot_ff;
   logic [GEN_BITS-1:0]     rsp_gen_ff;
   gha_pkg::status_type     rsp_status_ff;
   logic                    rsp_live_ff;
   logic [CNT_BITS-1:0]     rsp_total_ff;

   logic                    accept;
   logic                    out_free;
   logic                    finish;
   logic [ENTRY_BITS-1:0]   entry_rd;
   logic [ENTRY_BITS-1:0]   entry_wr;
   logic [STACK_BITS-1:0]   stack_rd;
   logic [SLOT_BITS-1:0]    stack_rd_addr;
   logic [SLOT_BITS-1:0]    stack_wr_addr;
   logic                    slot_known;
   logic [GEN_BITS-1:0]     cur_gen;
   logic                    cur_live;
   logic                    cur_pending;
   gha_pkg::ctrl_type       ctrl;
   logic [SLOT_BITS-1:0]    dec_slot;
   logic [GEN_BITS-1:0]     dec_gen;
   logic [SLOT_BITS-1:0]    wr_slot;
   logic [GEN_BITS-1:0]     wr_gen;
   logic                    wr_live;
   logic                    wr_pending;

   // Handshake: a beat enters only while the sequencer is idle.
   assign req_stall = (state_ff != gha_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == gha_pkg::ST_EXEC) && out_free;

   // Read addresses come straight from the request and the stack top.
   assign stack_rd_addr = SLOT_BITS'(free_depth_ff - CNT_BITS'(1));
   assign stack_wr_addr = free_depth_ff[SLOT_BITS-1:0];

   gha_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (finish && ctrl.slot_we),
      .wr_addr (wr_slot),
      .wr_data (entry_wr),
      .rd_en   (accept),
      .rd_addr (req_handle_slot),
      .rd_data (entry_rd)
   );

   gha_ram #(
      .WIDTH (STACK_BITS),
      .DEPTH (SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (finish && ctrl.push),
      .wr_addr (stack_wr_addr),
      .wr_data ({req_slot_ff, wr_gen}),
      .rd_en   (accept),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd)
   );

   // Slots never handed out read as all zero, whatever the memory holds.
   assign slot_known  = (CNT_BITS'(req_slot_ff) < high_water_ff);
   assign cur_gen     = slot_known ? entry_rd[ENTRY_BITS-1:2] : '0;
   assign cur_live    = slot_known && entry_rd[1];
   assign cur_pending = slot_known && entry_rd[0];
   assign entry_wr    = {wr_gen, wr_live, wr_pending};

   gha_decide #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS)
   ) u_decide (
      .req_type    (req_type_ff),
      .req_slot    (req_slot_ff),
      .req_gen     (req_gen_ff),
      .cur_gen     (cur_gen),
      .cur_live    (cur_live),
      .cur_pending (cur_pending),
      .top_slot    (stack_rd[STACK_BITS-1:GEN_BITS]),
      .top_gen     (stack_rd[GEN_BITS-1:0]),
      .free_depth  (free_depth_ff),
      .high_water  (high_water_ff),
      .ctrl        (ctrl),
      .out_slot    (dec_slot),
      .out_gen     (dec_gen),
      .wr_slot     (wr_slot),
      .wr_gen      (wr_gen),
      .wr_live     (wr_live),
      .wr_pending  (wr_pending)
   );

   // Next state of the sequencer and the counters.
   always_comb begin
      state_in      = state_ff;
      free_depth_in = free_depth_ff;
      high_water_in = high_water_ff;
      live_count_in = live_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         gha_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = gha_pkg::ST_EXEC;
            end
         end
         gha_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in     = gha_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (ctrl.pop) begin
                  free_depth_in = free_depth_ff - CNT_BITS'(1);
               end else if (ctrl.push) begin
                  free_depth_in = free_depth_ff + CNT_BITS'(1);
               end
               if (ctrl.hw_inc) begin
                  high_water_in = high_water_ff + CNT_BITS'(1);
               end
               if (ctrl.live_inc) begin
                  live_count_in = live_count_ff + CNT_BITS'(1);
               end else if (ctrl.live_dec && (live_count_ff != '0)) begin
                  live_count_in = live_count_ff - CNT_BITS'(1);
               end
            end
         end
         default: begin
            state_in = gha_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gha_pkg::ST_IDLE;
         free_depth_ff <= '0;
         high_water_ff <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_depth_ff <= free_depth_in;
         high_water_ff <= high_water_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Captured request and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff <= req_type;
         req_slot_ff <= req_handle_slot;
         req_gen_ff  <= req_handle_gen;
      end
      if (finish) begin
         rsp_slot_ff   <= dec_slot;
         rsp_gen_ff    <= dec_gen;
         rsp_status_ff <= ctrl.status;
         rsp_live_ff   <= ctrl.is_live;
         rsp_total_ff  <= live_count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_slot   = rsp_slot_ff;
   assign rsp_out_gen    = rsp_gen_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_is_live    = rsp_live_ff;
   assign rsp_live_total = rsp_total_ff;

   // Live and free slots are disjoint subsets of the slots handed out so far.
   a_counts_bounded : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, live_count_ff} + {1'b0, free_depth_ff}) <= {1'b0, high_water_ff})
      else $error("live plus free slots exceed the high-water mark");

   // The high-water mark never passes the number of slots.
   a_high_water_max : assert property (@(posedge clock) disable iff (reset)
      high_water_ff <= CNT_BITS'(SLOTS))
      else $error("high-water mark beyond slot count");

   // A no-free-slot result only appears once every slot has been handed out.
   a_full_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == gha_pkg::STATUS_NO_FREE))
      |-> (high_water_ff == CNT_BITS'(SLOTS)))
      else $error("no-free status while slots remain");

   // Write-back completes as soon as the result register can take the beat.
   a_exec_done : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gha_pkg::ST_EXEC) && out_free) |=> (state_ff == gha_pkg::ST_IDLE))
      else $error("write-back step did not complete");

   // A pop never happens on an empty stack.
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      (finish && ctrl.pop) |-> (free_depth_ff != '0))
      else $error("free stack popped while empty");

endmodule

/* src/gha_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* src/gha_decide.sv */
// Decision logic: checks a handle against the slot entry and picks the updates for one request.
`timescale 1ns / 1ps

module gha_decide #(
   parameter int SLOTS    = 1024,
   parameter int GEN_BITS = 16
) (
   input  logic [2:0]                   req_type,
   input  logic [$clog2(SLOTS)-1:0]     req_slot,
   input  logic [GEN_BITS-1:0]          req_gen,
   input  logic [GEN_BITS-1:0]          cur_gen,
   input  logic                         cur_live,
   input  logic                         cur_pending,
   input  logic [$clog2(SLOTS)-1:0]     top_slot,
   input  logic [GEN_BITS-1:0]          top_gen,
   input  logic [$clog2(SLOTS+1)-1:0]   free_depth,
   input  logic [$clog2(SLOTS+1)-1:0]   high_water,
   output gha_pkg::ctrl_type            ctrl,
   output logic [$clog2(SLOTS)-1:0]     out_slot,
   output logic [GEN_BITS-1:0]          out_gen,
   output logic [$clog2(SLOTS)-1:0]     wr_slot,
   output logic [GEN_BITS-1:0]          wr_gen,
   output logic                         wr_live,
   output logic                         wr_pending
);

   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int CNT_BITS  = $clog2(SLOTS + 1);
   localparam logic [CNT_BITS-1:0] SLOT_COUNT = CNT_BITS'(SLOTS);

   logic handle_ok;
   logic have_free;
   logic have_fresh;

   // A handle is valid only below the high-water mark with a matching generation.
   assign handle_ok  = (CNT_BITS'(req_slot) < high_water) &&
                       (cur_gen == req_gen);
   assign have_free  = (free_depth != '0);
   assign have_fresh = (high_water < SLOT_COUNT);

   // Per-request decision.
   always_comb begin
      ctrl       = '0;
      ctrl.status = gha_pkg::STATUS_DONE;
      out_slot   = req_slot;
      out_gen    = req_gen;
      wr_slot    = req_slot;
      wr_gen     = cur_gen;
      wr_live    = 1'b0;
      wr_pending = 1'b0;
      case (gha_pkg::req_code_type'(req_type))
         gha_pkg::REQ_CREATE, gha_pkg::REQ_RESERVE: begin
            if (have_free || have_fresh) begin
               if (have_free) begin
                  ctrl.pop = 1'b1;
                  wr_slot  = top_slot;
                  wr_gen   = top_gen;
               end else begin
                  ctrl.hw_inc = 1'b1;
                  wr_slot     = high_water[SLOT_BITS-1:0];
                  wr_gen      = '0;
               end
               ctrl.slot_we  = 1'b1;
               wr_live       = (req_type == gha_pkg::REQ_CREATE);
               wr_pending    = (req_type == gha_pkg::REQ_RESERVE);
               ctrl.live_inc = (req_type == gha_pkg::REQ_CREATE);
               out_slot      = wr_slot;
               out_gen       = wr_gen;
            end else begin
               ctrl.status = gha_pkg::STATUS_NO_FREE;
            end
         end
         gha_pkg::REQ_COMMIT: begin
            if (!handle_ok) begin
               ctrl.status = gha_pkg::STATUS_STALE;
            end else if (!cur_pending) begin
               ctrl.status = gha_pkg::STATUS_WRONG_STATE;
            end else begin
               ctrl.slot_we  = 1'b1;
               wr_live       = 1'b1;
               ctrl.live_inc = 1'b1;
            end
         end
         gha_pkg::REQ_DESTROY: begin
            if (!handle_ok) begin
               ctrl.status = gha_pkg::STATUS_STALE;
            end else if (cur_pending || cur_live) begin
               // Freeing bumps the generation and pushes the slot with it.
               ctrl.slot_we  = 1'b1;
               wr_gen        = cur_gen + GEN_BITS'(1);
               ctrl.push     = (free_depth < SLOT_COUNT);
               ctrl.live_dec = !cur_pending && cur_live;
            end else begin
               ctrl.status = gha_pkg::STATUS_WRONG_STATE;
            end
         end
         gha_pkg::REQ_QUERY: begin
            if (!handle_ok) begin
               ctrl.status = gha_pkg::STATUS_STALE;
            end else begin
               ctrl.is_live = cur_live;
            end
         end
         default: begin
            ctrl.status = gha_pkg::STATUS_WRONG_STATE;
         end
      endcase
   end

endmodule

/* test/generational_handle_allocator_unit_tb.sv */
// Self-checking testbench for the generational handle allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module generational_handle_allocator_unit_tb;

   localparam int SLOTS    = 1024;
   localparam int GEN_BITS = 16;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int TOTAL_W  = $clog2(SLOTS + 1);

   // Request codes the block does not define; they must be answered with a wrong-state status.
   localparam logic [2:0] REQ_SPARE_5 = 3'd5;
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;

   // Pools that a handle for commit, destroy or query is drawn from.
   localparam int POOL_PENDING = 0;
   localparam int POOL_HELD    = 1;
   localparam int POOL_ANY     = 2;

   localparam int RANDOM_BEATS = 1850;
   localparam int PAUSE_AT     = 900;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 5000;
   localparam int TAIL_CYCLES  = 20;
   localparam int DIR_ROWS     = 25;

   typedef struct {
      logic [SLOT_W-1:0]   slot;
      logic [GEN_BITS-1:0] gen;
      gha_pkg::status_type status;
      logic                is_live;
      logic [TOTAL_W-1:0]  total;
   } alloc_result_type;

   typedef struct {
      logic [2:0]          kind;
      logic [SLOT_W-1:0]   slot;
      logic [GEN_BITS-1:0] gen;
      bit                  typed;
      logic [SLOT_W-1:0]   want_slot;
      logic [GEN_BITS-1:0] want_gen;
      gha_pkg::status_type want_status;
      logic                want_live;
      logic [TOTAL_W-1:0]  want_total;
   } dir_row_type;

   typedef enum {
      ACT_CREATE, ACT_RESERVE, ACT_COMMIT, ACT_DESTROY,
      ACT_QUERY, ACT_STALE, ACT_SPARE, ACT_NOISE
   } act_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_type = gha_pkg::REQ_CREATE;
   logic [SLOT_W-1:0]   req_handle_slot = '0;
   logic [GEN_BITS-1:0] req_handle_gen = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SLOT_W-1:0]   rsp_out_slot;
   logic [GEN_BITS-1:0] rsp_out_gen;
   logic [1:0]          rsp_status;
   logic                rsp_is_live;
   logic [TOTAL_W-1:0]  rsp_live_total;

   // Shadow copy of the allocator state.
   bit [GEN_BITS-1:0]   gen_tab [SLOTS];
   bit                  live_tab [SLOTS];
   bit                  pend_tab [SLOTS];
   int                  free_lifo [$];
   int                  high_water = 0;
   int                  live_count = 0;
   int                  held_q [$];
   int                  pend_q [$];
   int                  no_free_seen = 0;

   alloc_result_type    result_q [$];
   alloc_result_type    oldest;
   int                  errors = 0;
   int                  req_beats = 0;
   int                  burst_left = 0;
   int                  idle_cycles = 0;

   generational_handle_allocator_unit #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_handle_slot (req_handle_slot),
      .req_handle_gen  (req_handle_gen),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_slot    (rsp_out_slot),
      .rsp_out_gen     (rsp_out_gen),
      .rsp_status      (rsp_status),
      .rsp_is_live     (rsp_is_live),
      .rsp_live_total  (rsp_live_total)
   );

   // Directed opening: reset state, every request kind, stale and misplaced handles,
   // reuse from the free stack, destroy of a reserved slot and the unused codes.
   // Each row: request, then the expected beat where the row is typed.
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{gha_pkg::REQ_QUERY,   10'd0,    16'h0000, 1'b1,
        10'd0,    16'h0000, gha_pkg::STATUS_STALE,       1'b0, 11'd0},
      '{gha_pkg::REQ_CREATE,  10'd1023, 16'hFFFF, 1'b1,
        10'd0,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd1},
      '{gha_pkg::REQ_RESERVE, 10'd0,    16'h0000, 1'b1,
        10'd1,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd1},
      '{gha_pkg::REQ_QUERY,   10'd1,    16'h0000, 1'b1,
        10'd1,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd1},
      '{gha_pkg::REQ_COMMIT,  10'd1,    16'hFFFF, 1'b1,
        10'd1,    16'hFFFF, gha_pkg::STATUS_STALE,       1'b0, 11'd1},
      '{gha_pkg::REQ_COMMIT,  10'd1,    16'h0000, 1'b1,
        10'd1,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd2},
      '{gha_pkg::REQ_COMMIT,  10'd1,    16'h0000, 1'b1,
        10'd1,    16'h0000, gha_pkg::STATUS_WRONG_STATE, 1'b0, 11'd2},
      '{gha_pkg::REQ_QUERY,   10'd1,    16'h0000, 1'b1,
        10'd1,    16'h0000, gha_pkg::STATUS_DONE,        1'b1, 11'd2},
      '{gha_pkg::REQ_DESTROY, 10'd0,    16'h0000, 1'b1,
        10'd0,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd1},
      '{gha_pkg::REQ_DESTROY, 10'd0,    16'h0000, 1'b1,
        10'd0,    16'h0000, gha_pkg::STATUS_STALE,       1'b0, 11'd1},
      '{gha_pkg::REQ_QUERY,   10'd0,    16'h0001, 1'b1,
        10'd0,    16'h0001, gha_pkg::STATUS_DONE,        1'b0, 11'd1},
      '{gha_pkg::REQ_DESTROY, 10'd0,    16'h0001, 1'b1,
        10'd0,    16'h0001, gha_pkg::STATUS_WRONG_STATE, 1'b0, 11'd1},
      '{gha_pkg::REQ_CREATE,  10'd0,    16'h0000, 1'b0,
        10'd0,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd0},
      '{gha_pkg::REQ_RESERVE, 10'd0,    16'h0000, 1'b0,
        10'd0,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd0},
      '{gha_pkg::REQ_DESTROY, 10'd2,    16'h0000, 1'b0,
        10'd0,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd0},
      '{gha_pkg::REQ_COMMIT,  10'd2,    16'h0001, 1'b0,
        10'd0,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd0},
      '{gha_pkg::REQ_RESERVE, 10'd0,    16'h0000, 1'b0,
        10'd0,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd0},
      '{gha_pkg::REQ_COMMIT,  10'd2,    16'h0001, 1'b0,
        10'd0,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd0},
      '{REQ_SPARE_5,          10'd1023, 16'hFFFF, 1'b1,
        10'd1023, 16'hFFFF, gha_pkg::STATUS_WRONG_STATE, 1'b0, 11'd3},
      '{REQ_SPARE_6,          10'h2AA,  16'h5555, 1'b1,
        10'h2AA,  16'h5555, gha_pkg::STATUS_WRONG_STATE, 1'b0, 11'd3},
      '{REQ_SPARE_7,          10'h155,  16'hAAAA, 1'b1,
        10'h155,  16'hAAAA, gha_pkg::STATUS_WRONG_STATE, 1'b0, 11'd3},
      '{gha_pkg::REQ_QUERY,   10'd1023, 16'h0000, 1'b1,
        10'd1023, 16'h0000, gha_pkg::STATUS_STALE,       1'b0, 11'd3},
      '{gha_pkg::REQ_DESTROY, 10'd1023, 16'hFFFF, 1'b1,
        10'd1023, 16'hFFFF, gha_pkg::STATUS_STALE,       1'b0, 11'd3},
      '{gha_pkg::REQ_COMMIT,  10'd0,    16'h0001, 1'b1,
        10'd0,    16'h0001, gha_pkg::STATUS_WRONG_STATE, 1'b0, 11'd3},
      '{gha_pkg::REQ_DESTROY, 10'd1,    16'h0000, 1'b1,
        10'd1,    16'h0000, gha_pkg::STATUS_DONE,        1'b0, 11'd2}
   };

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one request to the shadow state and return the result it should produce.
   function automatic alloc_result_type predict_request(input logic [2:0] kind,
                                                        input logic [SLOT_W-1:0] slot,
                                                        input logic [GEN_BITS-1:0] gen);
      alloc_result_type r;
      int               s;
      int               idx [$];
      bit               known;
      r.slot    = slot;
      r.gen     = gen;
      r.status  = gha_pkg::STATUS_DONE;
      r.is_live = 1'b0;
      known     = (int'(slot) < high_water) && (gen_tab[slot] == gen);
      case (kind)
         gha_pkg::REQ_CREATE, gha_pkg::REQ_RESERVE: begin
            // Reuse the most recently freed slot, else extend the high-water mark.
            if (free_lifo.size() != 0) begin
               s = free_lifo[$];
               free_lifo.delete(free_lifo.size() - 1);
            end else if (high_water < SLOTS) begin
               s = high_water;
               high_water++;
            end else begin
               s = -1;
            end
            if (s < 0) begin
               r.status = gha_pkg::STATUS_NO_FREE;
               no_free_seen++;
            end else begin
               held_q.insert(held_q.size(), s);
               if (kind == gha_pkg::REQ_CREATE) begin
                  live_tab[s] = 1'b1;
                  pend_tab[s] = 1'b0;
                  live_count++;
               end else begin
                  live_tab[s] = 1'b0;
                  pend_tab[s] = 1'b1;
                  pend_q.insert(pend_q.size(), s);
               end
               r.slot = SLOT_W'(s);
               r.gen  = gen_tab[s];
            end
         end
         gha_pkg::REQ_COMMIT: begin
            if (!known) begin
               r.status = gha_pkg::STATUS_STALE;
            end else if (!pend_tab[slot]) begin
               r.status = gha_pkg::STATUS_WRONG_STATE;
            end else begin
               pend_tab[slot] = 1'b0;
               live_tab[slot] = 1'b1;
               live_count++;
               idx = pend_q.find_first_index(x) with (x == int'(slot));
               if (idx.size() != 0) pend_q.delete(idx[0]);
            end
         end
         gha_pkg::REQ_DESTROY: begin
            // A reserved or live slot is freed; its generation moves on.
            if (!known) begin
               r.status = gha_pkg::STATUS_STALE;
            end else if (pend_tab[slot] || live_tab[slot]) begin
               if (live_tab[slot] && live_count > 0) live_count--;
               live_tab[slot] = 1'b0;
               pend_tab[slot] = 1'b0;
               gen_tab[slot]  = gen_tab[slot] + 1'b1;
               if (free_lifo.size() < SLOTS) free_lifo.insert(free_lifo.size(), int'(slot));
               idx = held_q.find_first_index(x) with (x == int'(slot));
               if (idx.size() != 0) held_q.delete(idx[0]);
               idx = pend_q.find_first_index(x) with (x == int'(slot));
               if (idx.size() != 0) pend_q.delete(idx[0]);
            end else begin
               r.status = gha_pkg::STATUS_WRONG_STATE;
            end
         end
         gha_pkg::REQ_QUERY: begin
            if (!known) r.status = gha_pkg::STATUS_STALE;
            else r.is_live = live_tab[slot];
         end
         default: begin
            r.status = gha_pkg::STATUS_WRONG_STATE;
         end
      endcase
      r.total = TOTAL_W'(live_count);
      return r;
   endfunction

   // Pick a slot for a handle, preferring the requested pool when it has entries.
   function automatic int pick_slot(input int pool);
      if (pool == POOL_PENDING && pend_q.size() != 0)
         return pend_q[$urandom_range(0, pend_q.size() - 1)];
      if (pool <= POOL_HELD && held_q.size() != 0)
         return held_q[$urandom_range(0, held_q.size() - 1)];
      if (high_water != 0)
         return $urandom_range(0, high_water - 1);
      return $urandom_range(0, SLOTS - 1);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // Offer one beat; the sender runs in bursts separated by random gaps.
   task automatic offer(input logic [2:0] kind, input logic [SLOT_W-1:0] slot,
                        input logic [GEN_BITS-1:0] gen);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 16);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_handle_slot <= slot;
      req_handle_gen  <= gen;
      do @(posedge clock); while (req_stall);
      burst_left--;
      req_beats++;
   endtask

   // Result side: compare every accepted beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            $error("result beat with nothing expected: slot %0h gen %0h",
                   rsp_out_slot, rsp_out_gen);
            errors++;
         end else begin
            oldest = result_q.pop_front();
            check_field("out_slot", oldest.slot, rsp_out_slot);
            check_field("out_gen", oldest.gen, rsp_out_gen);
            check_field("status", oldest.status, rsp_status);
            check_field("is_live", oldest.is_live, rsp_is_live);
            check_field("live_total", oldest.total, rsp_live_total);
         end
      end
   end

   // Receiver stalls follow a pattern drawn anew after each random span, and once it
   // holds off long enough for the block to back up into its request side.
   initial begin
      int  mode;
      int  span;
      bit  hold_done;
      hold_done = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(posedge clock);
            if (!hold_done && req_beats >= HOLD_AT) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Watchdog: too long without any beat on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("generational_handle_allocator_unit_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed table, then random traffic that first fills every slot
   // and then drains most of them again, refilling when few are held.
   initial begin
      alloc_result_type    r;
      alloc_result_type    typed_r;
      act_type             act;
      logic [2:0]          kind;
      logic [SLOT_W-1:0]   slot;
      logic [GEN_BITS-1:0] gen;
      int                  pick;
      int                  s;
      int                  counted;
      bit                  grow;
      bit                  paused;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; typed rows carry their own expectation.
      for (int i = 0; i < DIR_ROWS; i++) begin
         offer(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].gen);
         r = predict_request(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].gen);
         if (dir_rows[i].typed) begin
            typed_r.slot    = dir_rows[i].want_slot;
            typed_r.gen     = dir_rows[i].want_gen;
            typed_r.status  = dir_rows[i].want_status;
            typed_r.is_live = dir_rows[i].want_live;
            typed_r.total   = dir_rows[i].want_total;
            result_q.insert(result_q.size(), typed_r);
         end else begin
            result_q.insert(result_q.size(), r);
         end
      end

      counted = 0;
      grow    = 1'b1;
      paused  = 1'b0;
      while (counted < RANDOM_BEATS) begin
         // Choose an action; the mix leans on allocation while growing.
         pick = $urandom_range(0, 99);
         if (grow) begin
            act = (pick < 60) ? ACT_CREATE : (pick < 75) ? ACT_RESERVE :
                  (pick < 83) ? ACT_COMMIT : (pick < 88) ? ACT_QUERY :
                  (pick < 91) ? ACT_DESTROY : (pick < 95) ? ACT_STALE :
                  (pick < 97) ? ACT_SPARE : ACT_NOISE;
         end else begin
            act = (pick < 10) ? ACT_CREATE : (pick < 15) ? ACT_RESERVE :
                  (pick < 25) ? ACT_COMMIT : (pick < 35) ? ACT_QUERY :
                  (pick < 80) ? ACT_DESTROY : (pick < 90) ? ACT_STALE :
                  (pick < 93) ? ACT_SPARE : ACT_NOISE;
         end

         slot = SLOT_W'($urandom);
         gen  = GEN_BITS'($urandom);
         case (act)
            ACT_CREATE:  kind = gha_pkg::REQ_CREATE;
            ACT_RESERVE: kind = gha_pkg::REQ_RESERVE;
            ACT_COMMIT, ACT_DESTROY, ACT_QUERY: begin
               if (act == ACT_COMMIT) begin
                  kind = gha_pkg::REQ_COMMIT;
                  s    = pick_slot(($urandom_range(0, 4) != 0) ? POOL_PENDING : POOL_HELD);
               end else if (act == ACT_DESTROY) begin
                  kind = gha_pkg::REQ_DESTROY;
                  s    = pick_slot(($urandom_range(0, 9) != 0) ? POOL_HELD : POOL_ANY);
               end else begin
                  kind = gha_pkg::REQ_QUERY;
                  s    = pick_slot(($urandom_range(0, 1) != 0) ? POOL_HELD : POOL_ANY);
               end
               slot = SLOT_W'(s);
               if (s < high_water) gen = gen_tab[s];
            end
            ACT_STALE: begin
               // Either a known slot with a wrong generation or a slot at or above the mark.
               kind = ($urandom_range(0, 2) == 0) ? gha_pkg::REQ_COMMIT :
                      ($urandom_range(0, 1) == 0) ? gha_pkg::REQ_DESTROY :
                      gha_pkg::REQ_QUERY;
               if (high_water != 0 && (high_water == SLOTS || $urandom_range(0, 1) == 0)) begin
                  s    = $urandom_range(0, high_water - 1);
                  slot = SLOT_W'(s);
                  gen  = gen_tab[s] ^ (GEN_BITS'(1) << $urandom_range(0, GEN_BITS - 1));
               end else begin
                  slot = SLOT_W'($urandom_range(high_water, SLOTS - 1));
               end
            end
            ACT_SPARE: kind = 3'($urandom_range(REQ_SPARE_5, REQ_SPARE_7));
            default:   kind = 3'($urandom_range(0, 7));
         endcase

         offer(kind, slot, gen);
         result_q.insert(result_q.size(), predict_request(kind, slot, gen));
         counted++;

         // Once the allocator has refused several times, drain it; refill when low.
         if (grow && no_free_seen >= 4) grow = 1'b0;
         else if (!grow && held_q.size() < 40) grow = 1'b1;

         // One pause on the request side until every result is back.
         if (!paused && counted >= PAUSE_AT) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            burst_left = 0;
            while (result_q.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray beat.
      while (result_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && result_q.size() == 0) begin
         $display("generational_handle_allocator_unit_tb: done, clean");
      end else begin
         $display("generational_handle_allocator_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
